@@ rtl/core/circular_queue_with_traverse_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Circular queue with traverse: assertion macros
// Shared concurrent assertion forms, clocked on clock, held off in reset.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_QUEUE_WITH_TRAVERSE_UNIT_MACROS_SVH
`define CIRCULAR_QUEUE_WITH_TRAVERSE_UNIT_MACROS_SVH

// same-cycle implication
`define CQT_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CQT_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/cqt_pkg.sv @@
// ----------------------------------------------------------------------------
// Circular queue with traverse: package
// Sizes, request and status codes, and the front-to-back command record.
// ----------------------------------------------------------------------------
package cqt_pkg;

   localparam int DEPTH      = 64;
   localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int DATA_W     = 32;
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_ENQ  = 2'd0,
      KIND_DEQ  = 2'd1,
      KIND_TRAV = 2'd2,
      KIND_STAT = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      kind_type                   kind;
      logic signed [DATA_W-1:0]   value;
   } cmd_type;

endpackage

@@ rtl/core/cqt_front.sv @@
// ----------------------------------------------------------------------------
// Circular queue with traverse: front end
// Accepts request transactions, decodes the kind and buffers them in a
// short command queue for the back end.
// ----------------------------------------------------------------------------
module cqt_front
   import cqt_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_type,
   input  logic signed [DATA_W-1:0]  req_value,
   output logic                      cmd_valid,
   output cmd_type                   cmd,
   input  logic                      cmd_pop
);

   cmd_type                 entry_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CNT_W-1:0]   count_ff, count_in;
   logic                    push;
   logic                    pop;

   assign req_ready = (count_ff != CMDQ_CNT_W'(CMDQ_DEPTH));
   assign push      = req_valid && req_ready;
   assign cmd_valid = (count_ff != '0);
   assign pop       = cmd_pop && cmd_valid;
   assign cmd       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= '{kind: kind_type'(req_type), value: req_value};
      end
   end

endmodule

@@ rtl/core/cqt_back.sv @@
// ----------------------------------------------------------------------------
// Circular queue with traverse: back end
// Holds the slot storage and pointers, executes commands, streams traverse
// results and drives the registered response transaction.
// ----------------------------------------------------------------------------
`include "circular_queue_with_traverse_unit_macros.svh"

module cqt_back
   import cqt_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      cmd_valid,
   input  cmd_type                   cmd,
   output logic                      cmd_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_status,
   output logic signed [DATA_W-1:0]  rsp_data,
   output logic                      rsp_now_empty,
   output logic                      rsp_now_full,
   output logic                      rsp_last
);

   typedef enum logic {
      S_CMD,
      S_TRAV
   } state_type;

   logic [DATA_W-1:0]   mem [DEPTH];
   logic [DATA_W-1:0]   rd_data_ff;

   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    head_ff, head_in;
   logic [IDX_W-1:0]    tail_ff, tail_in;
   logic [CNT_W-1:0]    occ_ff, occ_in;
   logic [IDX_W-1:0]    trav_idx_ff, trav_idx_in;
   logic [CNT_W-1:0]    trav_left_ff, trav_left_in;

   logic                p_valid_ff, p_valid_in;
   status_type          p_status_ff, p_status_in;
   logic                p_use_rd_ff, p_use_rd_in;
   logic                p_empty_ff, p_empty_in;
   logic                p_full_ff, p_full_in;
   logic                p_last_ff, p_last_in;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                rsp_empty_ff, rsp_empty_in;
   logic                rsp_full_ff, rsp_full_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                p_move;
   logic                can_issue;
   logic                issue;
   logic                wr_en;
   logic                rd_en;
   logic [IDX_W-1:0]    rd_addr;
   logic                q_empty;
   logic                is_full;

   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
      return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
   endfunction

   assign q_empty   = (occ_ff == '0);
   assign is_full   = (occ_ff == CNT_W'(DEPTH));
   assign p_move    = p_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign can_issue = !p_valid_ff || p_move;

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      occ_in       = occ_ff;
      trav_idx_in  = trav_idx_ff;
      trav_left_in = trav_left_ff;
      issue        = 1'b0;
      cmd_pop      = 1'b0;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = head_ff;
      p_status_in  = p_status_ff;
      p_use_rd_in  = p_use_rd_ff;
      p_last_in    = p_last_ff;

      case (state_ff)
         S_CMD: begin
            if (cmd_valid && can_issue) begin
               issue       = 1'b1;
               cmd_pop     = 1'b1;
               p_status_in = STATUS_OK;
               p_use_rd_in = 1'b0;
               p_last_in   = 1'b1;
               case (cmd.kind)
                  KIND_ENQ: begin
                     if (is_full) begin
                        p_status_in = STATUS_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        tail_in = next_idx(tail_ff);
                        occ_in  = occ_ff + 1'b1;
                     end
                  end
                  KIND_DEQ: begin
                     if (q_empty) begin
                        p_status_in = STATUS_EMPTY;
                     end else begin
                        rd_en       = 1'b1;
                        p_use_rd_in = 1'b1;
                        head_in     = next_idx(head_ff);
                        occ_in      = occ_ff - 1'b1;
                     end
                  end
                  KIND_TRAV: begin
                     if (q_empty) begin
                        p_status_in = STATUS_EMPTY;
                     end else begin
                        rd_en        = 1'b1;
                        p_use_rd_in  = 1'b1;
                        trav_idx_in  = next_idx(head_ff);
                        trav_left_in = occ_ff - 1'b1;
                        if (occ_ff != CNT_W'(1)) begin
                           p_last_in = 1'b0;
                           state_in  = S_TRAV;
                        end
                     end
                  end
                  default: begin
                     p_status_in = STATUS_OK;
                  end
               endcase
            end
         end
         S_TRAV: begin
            rd_addr = trav_idx_ff;
            if (can_issue) begin
               issue        = 1'b1;
               rd_en        = 1'b1;
               p_status_in  = STATUS_OK;
               p_use_rd_in  = 1'b1;
               p_last_in    = (trav_left_ff == CNT_W'(1));
               trav_idx_in  = next_idx(trav_idx_ff);
               trav_left_in = trav_left_ff - 1'b1;
               if (trav_left_ff == CNT_W'(1)) begin
                  state_in = S_CMD;
               end
            end
         end
         default: begin
            state_in = S_CMD;
         end
      endcase

      p_valid_in = issue || (p_valid_ff && !p_move);
      p_empty_in = issue ? (occ_in == '0) : p_empty_ff;
      p_full_in  = issue ? (occ_in == CNT_W'(DEPTH)) : p_full_ff;

      rsp_valid_in  = p_move || (rsp_valid_ff && !rsp_ready);
      rsp_status_in = p_move ? p_status_ff : rsp_status_ff;
      rsp_data_in   = p_move ? (p_use_rd_ff ? rd_data_ff : '0) : rsp_data_ff;
      rsp_empty_in  = p_move ? p_empty_ff : rsp_empty_ff;
      rsp_full_in   = p_move ? p_full_ff : rsp_full_ff;
      rsp_last_in   = p_move ? p_last_ff : rsp_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CMD;
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         p_valid_ff   <= p_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      trav_idx_ff   <= trav_idx_in;
      trav_left_ff  <= trav_left_in;
      p_status_ff   <= p_status_in;
      p_use_rd_ff   <= p_use_rd_in;
      p_empty_ff    <= p_empty_in;
      p_full_ff     <= p_full_in;
      p_last_ff     <= p_last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_full_ff   <= rsp_full_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // slot storage, single write and single registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[tail_ff] <= cmd.value;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_data      = rsp_data_ff;
   assign rsp_now_empty = rsp_empty_ff;
   assign rsp_now_full  = rsp_full_ff;
   assign rsp_last      = rsp_last_ff;

   `CQT_ASSERT_IMP(a_occ_range, 1'b1, occ_ff <= CNT_W'(DEPTH), "occupancy beyond depth")
   `CQT_ASSERT_IMP(a_ptr_meet, (occ_ff == '0) || (occ_ff == CNT_W'(DEPTH)), head_ff == tail_ff, "pointers disagree with occupancy")
   `CQT_ASSERT_IMP(a_trav_left, state_ff == S_TRAV, (trav_left_ff != '0) && (trav_left_ff < occ_ff), "traverse count out of step")
   `CQT_ASSERT_NXT(a_occ_hold, state_ff == S_TRAV, $stable(occ_ff), "occupancy changed during traverse")

endmodule

@@ rtl/core/circular_queue_with_traverse_unit.sv @@
// A circular FIFO of 64 signed 32-bit words with enqueue, dequeue, traverse and status requests.
// Requests enter a two-entry command queue and are executed in order by the back end. Enqueue,
// dequeue and status each give one response; traverse streams one response per cycle, while
// the response side accepts them, from head to tail, marking the final one with last, and
// holds later commands until it ends. The slot memory has a single write and a single
// registered read, and the back end uses at most one of them per cycle. A request passes
// through the command queue entry, then the issue stage that holds the registered memory read
// and its status, then the response output register; each of these holds it while the next
// is stalled. Every response carries the empty and full flags as they stand after its request.
// ----------------------------------------------------------------------------
// Circular queue with traverse: top level
// Joins the request front end and the execution back end.
// ----------------------------------------------------------------------------
module circular_queue_with_traverse_unit
   import cqt_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_type,
   input  logic signed [DATA_W-1:0]  req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_status,
   output logic signed [DATA_W-1:0]  rsp_data,
   output logic                      rsp_now_empty,
   output logic                      rsp_now_full,
   output logic                      rsp_last
);

   logic      cmd_valid;
   cmd_type   cmd;
   logic      cmd_pop;

   cqt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .req_value (req_value),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   cqt_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_pop       (cmd_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_data      (rsp_data),
      .rsp_now_empty (rsp_now_empty),
      .rsp_now_full  (rsp_now_full),
      .rsp_last      (rsp_last)
   );

endmodule

@@ dv/tb_circular_queue_with_traverse_unit.sv @@
// ----------------------------------------------------------------------------
// Circular queue with traverse: testbench
// Sends enqueue, dequeue, traverse and status requests with random gaps while
// the response side stalls at random. A shadow queue predicts every response,
// and each received response is compared field by field, in order.
// ----------------------------------------------------------------------------
module tb_circular_queue_with_traverse_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import cqt_pkg::*;

   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int SETTLE_WAIT  = 20;
   localparam int RANDOM_ITEMS = 150;
   localparam int PRINT_CAP    = 40;

   typedef struct {
      kind_type                 kind;
      logic signed [DATA_W-1:0] value;
      int unsigned              gap;
      bit                       wait_drain;
   } request_type;

   typedef struct {
      status_type               status;
      logic signed [DATA_W-1:0] data;
      logic                     now_empty;
      logic                     now_full;
      logic                     last;
   } response_type;

   logic                     clock         = 1'b0;
   logic                     reset         = 1'b1;
   logic                     req_valid     = 1'b0;
   logic                     req_ready;
   logic [1:0]               req_type      = '0;
   logic signed [DATA_W-1:0] req_value     = '0;
   logic                     rsp_valid;
   logic                     rsp_ready     = 1'b0;
   logic [1:0]               rsp_status;
   logic signed [DATA_W-1:0] rsp_data;
   logic                     rsp_now_empty;
   logic                     rsp_now_full;
   logic                     rsp_last;

   request_type  pending_requests[$];
   response_type expected_responses[$];

   // shadow of the queue contents
   logic signed [DATA_W-1:0] shadow_slots[DEPTH];
   logic [IDX_W-1:0]         shadow_head  = '0;
   logic [IDX_W-1:0]         shadow_tail  = '0;
   int unsigned              shadow_count = 0;

   int unsigned planned_count  = 0;
   int unsigned planned_fill   = 0;
   int unsigned cycle_count    = 0;
   int unsigned mismatch_count = 0;
   int unsigned checked_count  = 0;
   int unsigned full_rejects   = 0;
   int unsigned empty_answers  = 0;
   int unsigned kind_counts[4] = '{0, 0, 0, 0};
   int unsigned ready_stall    = 0;

   circular_queue_with_traverse_unit dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_type      (req_type),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_data      (rsp_data),
      .rsp_now_empty (rsp_now_empty),
      .rsp_now_full  (rsp_now_full),
      .rsp_last      (rsp_last)
   );

   always #1 clock = ~clock;

   task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                  logic [DATA_W-1:0] want);
      if (mismatch_count < PRINT_CAP)
         $display("[%0t] MISMATCH %s: got 0x%08h, expected 0x%08h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   function automatic void push_response(status_type status, logic signed [DATA_W-1:0] data,
                                         logic last);
      response_type r;
      r.status    = status;
      r.data      = data;
      r.now_empty = (shadow_count == 0);
      r.now_full  = (shadow_count == DEPTH);
      r.last      = last;
      expected_responses.push_back(r);
   endfunction

   function automatic void apply_queue_request(kind_type kind, logic signed [DATA_W-1:0] value);
      logic [IDX_W-1:0] idx;
      kind_counts[kind]++;
      case (kind)
         KIND_ENQ: begin
            if (shadow_count == DEPTH) begin
               push_response(STATUS_FULL, '0, 1'b1);
            end else begin
               shadow_slots[shadow_tail] = value;
               shadow_tail = shadow_tail + 1'b1;
               shadow_count++;
               push_response(STATUS_OK, '0, 1'b1);
            end
         end
         KIND_DEQ: begin
            if (shadow_count == 0) begin
               push_response(STATUS_EMPTY, '0, 1'b1);
            end else begin
               idx = shadow_head;
               shadow_head = shadow_head + 1'b1;
               shadow_count--;
               push_response(STATUS_OK, shadow_slots[idx], 1'b1);
            end
         end
         KIND_TRAV: begin
            if (shadow_count == 0) begin
               push_response(STATUS_EMPTY, '0, 1'b1);
            end else begin
               idx = shadow_head;
               for (int k = 0; k < shadow_count; k++) begin
                  push_response(STATUS_OK, shadow_slots[idx], k + 1 == shadow_count);
                  idx = idx + 1'b1;
               end
            end
         end
         default: push_response(STATUS_OK, '0, 1'b1);
      endcase
   endfunction

   // request driver
   always @(posedge clock) begin
      request_type next_req;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            apply_queue_request(kind_type'(req_type), req_value);
         if (!req_valid || req_ready) begin
            if (pending_requests.size() == 0) begin
               req_valid <= 1'b0;
            end else if (pending_requests[0].gap != 0) begin
               pending_requests[0].gap--;
               req_valid <= 1'b0;
            end else if (pending_requests[0].wait_drain && expected_responses.size() != 0) begin
               req_valid <= 1'b0;
            end else begin
               next_req = pending_requests.pop_front();
               req_valid <= 1'b1;
               req_type  <= next_req.kind;
               req_value <= next_req.value;
            end
         end
      end
   end

   // response back-pressure, with calm stretches
   always @(posedge clock) begin
      int unsigned r;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (ready_stall != 0) begin
         ready_stall--;
         rsp_ready <= 1'b0;
      end else if (cycle_count % 600 < 150) begin
         rsp_ready <= 1'b1;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 10) begin
            ready_stall = $urandom_range(0, 2);
            rsp_ready <= 1'b0;
         end else if (r < 12) begin
            ready_stall = $urandom_range(8, 40);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      response_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_responses.size() == 0) begin
            report_mismatch("response with nothing outstanding", rsp_data, '0);
         end else begin
            want = expected_responses.pop_front();
            checked_count++;
            if (want.status == STATUS_FULL)  full_rejects++;
            if (want.status == STATUS_EMPTY) empty_answers++;
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_data !== want.data)
               report_mismatch("data", rsp_data, want.data);
            if (rsp_now_empty !== want.now_empty)
               report_mismatch("now_empty", rsp_now_empty, want.now_empty);
            if (rsp_now_full !== want.now_full)
               report_mismatch("now_full", rsp_now_full, want.now_full);
            if (rsp_last !== want.last)
               report_mismatch("last", rsp_last, want.last);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[%0t] timeout, %0d responses outstanding", $realtime,
                  expected_responses.size());
         $display("circular_queue_with_traverse_unit test failed");
         $finish;
      end
   end

   function automatic int unsigned pick_gap(bit calm);
      int unsigned r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_word();
      case ($urandom_range(0, 19))
         0:       return {1'b1, {(DATA_W-1){1'b0}}};
         1:       return {1'b0, {(DATA_W-1){1'b1}}};
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // planned_fill tracks the occupancy the request list will leave behind
   function automatic void add_request(kind_type kind, logic signed [DATA_W-1:0] value,
                                       bit calm, bit wait_drain);
      request_type r;
      r.kind       = kind;
      r.value      = value;
      r.gap        = pick_gap(calm);
      r.wait_drain = wait_drain;
      pending_requests.push_back(r);
      planned_count++;
      if (kind == KIND_ENQ && planned_fill < DEPTH) planned_fill++;
      if (kind == KIND_DEQ && planned_fill > 0)     planned_fill--;
   endfunction

   initial begin
      int unsigned sel;
      int unsigned n;
      bit          calm;
      bit          first_pass;
      kind_type    kind;

      // directed opening
      add_request(KIND_STAT, '0, 1'b0, 1'b0);
      add_request(KIND_DEQ,  '1, 1'b0, 1'b0);
      add_request(KIND_TRAV, '0, 1'b0, 1'b0);
      add_request(KIND_ENQ,  {1'b0, {(DATA_W-1){1'b1}}}, 1'b1, 1'b0);
      add_request(KIND_ENQ,  {1'b1, {(DATA_W-1){1'b0}}}, 1'b1, 1'b0);
      add_request(KIND_ENQ,  '0, 1'b1, 1'b0);
      add_request(KIND_ENQ,  '1, 1'b1, 1'b0);
      add_request(KIND_ENQ,  32'h5555_5555, 1'b0, 1'b0);
      add_request(KIND_ENQ,  32'hAAAA_AAAA, 1'b0, 1'b0);
      add_request(KIND_STAT, '1, 1'b0, 1'b0);
      add_request(KIND_TRAV, '1, 1'b1, 1'b0);
      add_request(KIND_DEQ,  '0, 1'b1, 1'b0);
      add_request(KIND_DEQ,  '0, 1'b1, 1'b0);
      add_request(KIND_TRAV, '0, 1'b0, 1'b0);
      add_request(KIND_STAT, '0, 1'b0, 1'b1);
      repeat (4) add_request(KIND_DEQ, '0, 1'b0, 1'b0);
      add_request(KIND_DEQ,  '0, 1'b0, 1'b0);
      add_request(KIND_TRAV, '0, 1'b0, 1'b0);

      // random part: fill bursts, drain bursts and mixed traffic
      first_pass = 1'b1;
      n = planned_count + RANDOM_ITEMS;
      while (planned_count < n) begin
         calm = ($urandom_range(0, 3) == 0);
         sel  = first_pass ? 0 : $urandom_range(0, 99);
         first_pass = 1'b0;
         if (sel < 10) begin
            repeat (DEPTH - planned_fill + $urandom_range(1, 2))
               add_request(KIND_ENQ, pick_word(), calm, 1'b0);
            add_request(KIND_TRAV, pick_word(), calm, 1'b0);
            add_request(KIND_STAT, pick_word(), calm, 1'b0);
         end else if (sel < 20) begin
            repeat (planned_fill + 1)
               add_request(KIND_DEQ, pick_word(), calm, 1'b0);
            add_request(KIND_TRAV, pick_word(), calm, 1'b0);
         end else begin
            repeat ($urandom_range(4, 12)) begin
               sel = $urandom_range(0, 99);
               if (sel < 42)      kind = KIND_ENQ;
               else if (sel < 72) kind = KIND_DEQ;
               else if (sel < 86) kind = KIND_TRAV;
               else               kind = KIND_STAT;
               add_request(kind, pick_word(), calm, $urandom_range(0, 24) == 0);
            end
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (pending_requests.size() != 0 || req_valid || expected_responses.size() != 0)
         @(negedge clock);
      repeat (SETTLE_WAIT) @(negedge clock);

      $display("Sent %0d requests: %0d enqueue, %0d dequeue, %0d traverse, %0d status",
               kind_counts[KIND_ENQ] + kind_counts[KIND_DEQ] + kind_counts[KIND_TRAV]
               + kind_counts[KIND_STAT], kind_counts[KIND_ENQ], kind_counts[KIND_DEQ],
               kind_counts[KIND_TRAV], kind_counts[KIND_STAT]);
      $display("Checked %0d responses (%0d full rejections, %0d empty answers), %0d mismatches",
               checked_count, full_rejects, empty_answers, mismatch_count);
      if (mismatch_count == 0 && expected_responses.size() == 0) begin
         $display("circular_queue_with_traverse_unit test passed");
      end else begin
         $display("circular_queue_with_traverse_unit test failed");
      end
      $finish;
   end

endmodule

@@ circular_queue_with_traverse_unit.f @@
+incdir+rtl/core
rtl/core/cqt_pkg.sv
rtl/core/cqt_front.sv
rtl/core/cqt_back.sv
rtl/core/circular_queue_with_traverse_unit.sv
dv/tb_circular_queue_with_traverse_unit.sv
